### hw/rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg: shared types and constants of the calendar date arithmetic block
// Holds the date type, the operation and sequencer codes and the calendar
// helper functions used by the top level and the day stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int DIST_W = 22;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MON_W-1:0]  MON_MIN  = 4'd1;
    localparam logic [MON_W-1:0]  MON_MAX  = 4'd12;
    localparam logic [DAY_W-1:0]  DAY_MIN  = 5'd1;
    localparam logic [DAY_W-1:0]  DAY_MAX  = 5'd31;

    // Year is the most significant member, so packed dates order as calendar dates.
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
    } date_t;

    localparam date_t DATE_MIN = '{year: YEAR_MIN, month: MON_MIN, day: DAY_MIN};
    localparam date_t DATE_MAX = '{year: YEAR_MAX, month: MON_MAX, day: DAY_MAX};

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_CMP = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP_A,
        ST_CLAMP_B,
        ST_RUN,
        ST_FINISH
    } state_t;

    // Leap test for years up to 9999. The quotient by 100 comes from a
    // reciprocal multiply, which is exact over that range.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [27:0] prod;
        logic [8:0]  q100;
        logic        div100;
        logic        div400;
        prod   = 28'(y) * 28'd5243;
        q100   = prod[27:19];
        div100 = (14'(q100) * 14'd100) == y;
        div400 = div100 && (q100[1:0] == 2'd0);
        return ((y[1:0] == 2'd0) && !div100) || div400;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cda_day_step.sv
// ----------------------------------------------------------------------------
// cda_day_step: shared one-day stepper
// Moves a valid date one day forward or backward and reports the length of
// the month of the incoming date, which the clamp stage also uses.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_day_step (
    input  cda_pkg::date_t           date_in,
    input  logic                     down,
    output cda_pkg::date_t           date_out,
    output logic [cda_pkg::DAY_W-1:0] days_in_month
);
    import cda_pkg::*;

    logic             leap;
    logic [MON_W-1:0] mon_prev;
    logic [DAY_W-1:0] prev_len;

    assign leap          = is_leap(date_in.year);
    assign days_in_month = month_days(date_in.month, leap);
    assign mon_prev      = date_in.month - 4'd1;
    assign prev_len      = month_days(mon_prev, leap);

    always_comb
    begin
        date_out = date_in;
        if (!down)
        begin
            if (date_in.day < days_in_month)
            begin
                date_out.day = date_in.day + 5'd1;
            end
            else if (date_in.month < MON_MAX)
            begin
                date_out.day   = DAY_MIN;
                date_out.month = date_in.month + 4'd1;
            end
            else
            begin
                date_out.day   = DAY_MIN;
                date_out.month = MON_MIN;
                date_out.year  = date_in.year + 14'd1;
            end
        end
        else
        begin
            if (date_in.day > DAY_MIN)
            begin
                date_out.day = date_in.day - 5'd1;
            end
            else if (date_in.month > MON_MIN)
            begin
                date_out.day   = prev_len;
                date_out.month = mon_prev;
            end
            else
            begin
                date_out.day   = DAY_MAX;
                date_out.month = MON_MAX;
                date_out.year  = date_in.year - 14'd1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/calendar_date_arithmetic.sv
// ----------------------------------------------------------------------------
// calendar_date_arithmetic: Gregorian date add, subtract and compare
// Clamps the incoming dates, then walks one day per cycle through the shared
// day stepper until the count is used up, a date bound or the later date is reached.
// ----------------------------------------------------------------------------
// Sequence: add and subtract pass ST_CLAMP_A, ST_RUN and ST_FINISH, stepping
// min(delta_days, days to the bound) days in ST_RUN; compare also passes ST_CLAMP_B
// and steps the distance in days; an unused kind goes from ST_CLAMP_A to ST_FINISH.
// Throughput: one request at a time; in_ready is high only while idle, and rises
// on the same edge that loads the result. The single day stepper serialises the work.
// Reset clears the sequencer and the output valid; there is no stored memory.
`default_nettype none

module calendar_date_arithmetic #(
    parameter int DELTA_BITS = 22
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 kind,
    input  logic [4:0]                 day_a,
    input  logic [3:0]                 month_a,
    input  logic [13:0]                year_a,
    input  logic [4:0]                 day_b,
    input  logic [3:0]                 month_b,
    input  logic [13:0]                year_b,
    input  logic [DELTA_BITS-1:0]      delta_days,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [4:0]                 day_out,
    output logic [3:0]                 month_out,
    output logic [13:0]                year_out,
    output logic [21:0]                distance_days,
    output logic                       a_before_b,
    output logic                       a_equals_b,
    output logic                       range_error
);
    import cda_pkg::*;

    state_t                state_reg, state_next;
    logic [1:0]            kind_reg, kind_next;
    date_t                 raw_a_reg, raw_a_next;
    date_t                 raw_b_reg, raw_b_next;
    date_t                 cur_reg, cur_next;
    date_t                 tgt_reg, tgt_next;
    logic [DELTA_BITS-1:0] cnt_reg, cnt_next;
    logic [DIST_W-1:0]     dist_reg, dist_next;
    logic                  err_reg, err_next;
    logic                  before_reg, before_next;
    logic                  equal_reg, equal_next;

    logic                  out_valid_reg, out_valid_next;
    date_t                 out_date_reg, out_date_next;
    logic [DIST_W-1:0]     out_dist_reg, out_dist_next;
    logic                  out_before_reg, out_before_next;
    logic                  out_equal_reg, out_equal_next;
    logic                  out_err_reg, out_err_next;

    date_t                 raw_sel;
    logic [MON_W-1:0]      mon_c;
    logic [YEAR_W-1:0]     year_c;
    logic [DAY_W-1:0]      day_c;
    date_t                 clamped;
    date_t                 unit_in;
    date_t                 unit_out;
    logic [DAY_W-1:0]      unit_dim;
    logic                  unit_down;
    logic                  accept;
    logic                  out_free;
    logic                  run_done;
    logic                  run_err;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Month and year are clamped first; the day clamp needs the month length.
    assign raw_sel = (state_reg == ST_CLAMP_A) ? raw_a_reg : raw_b_reg;

    always_comb
    begin
        if (raw_sel.month < MON_MIN)
            mon_c = MON_MIN;
        else if (raw_sel.month > MON_MAX)
            mon_c = MON_MAX;
        else
            mon_c = raw_sel.month;

        if (raw_sel.year < YEAR_MIN)
            year_c = YEAR_MIN;
        else if (raw_sel.year > YEAR_MAX)
            year_c = YEAR_MAX;
        else
            year_c = raw_sel.year;
    end

    always_comb
    begin
        if ((state_reg == ST_CLAMP_A) || (state_reg == ST_CLAMP_B))
            unit_in = '{year: year_c, month: mon_c, day: raw_sel.day};
        else
            unit_in = cur_reg;
    end

    assign unit_down = (kind_reg == KIND_SUB);

    cda_day_step u_step (
        .date_in       (unit_in),
        .down          (unit_down),
        .date_out      (unit_out),
        .days_in_month (unit_dim)
    );

    always_comb
    begin
        if (raw_sel.day < DAY_MIN)
            day_c = DAY_MIN;
        else if (raw_sel.day > unit_dim)
            day_c = unit_dim;
        else
            day_c = raw_sel.day;
    end

    assign clamped = '{year: year_c, month: mon_c, day: day_c};

    // Termination of the day walk for the current operation.
    always_comb
    begin
        run_done = 1'b1;
        run_err  = 1'b0;
        case (kind_reg)
            KIND_ADD:
            begin
                run_done = (cnt_reg == '0) || (cur_reg == DATE_MAX);
                run_err  = (cnt_reg != '0) && (cur_reg == DATE_MAX);
            end
            KIND_SUB:
            begin
                run_done = (cnt_reg == '0) || (cur_reg == DATE_MIN);
                run_err  = (cnt_reg != '0) && (cur_reg == DATE_MIN);
            end
            KIND_CMP:
            begin
                run_done = (cur_reg == tgt_reg);
            end
            default:
            begin
                run_done = 1'b1;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CLAMP_A;
            end
            ST_CLAMP_A:
            begin
                if (kind_reg == KIND_CMP)
                    state_next = ST_CLAMP_B;
                else if ((kind_reg == KIND_ADD) || (kind_reg == KIND_SUB))
                    state_next = ST_RUN;
                else
                    state_next = ST_FINISH;
            end
            ST_CLAMP_B:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (run_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result register updates.
    always_comb
    begin
        kind_next       = kind_reg;
        raw_a_next      = raw_a_reg;
        raw_b_next      = raw_b_reg;
        cur_next        = cur_reg;
        tgt_next        = tgt_reg;
        cnt_next        = cnt_reg;
        dist_next       = dist_reg;
        err_next        = err_reg;
        before_next     = before_reg;
        equal_next      = equal_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        out_date_next   = out_date_reg;
        out_dist_next   = out_dist_reg;
        out_before_next = out_before_reg;
        out_equal_next  = out_equal_reg;
        out_err_next    = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind;
                    raw_a_next = '{year: year_a, month: month_a, day: day_a};
                    raw_b_next = '{year: year_b, month: month_b, day: day_b};
                    cnt_next   = delta_days;
                end
            end
            ST_CLAMP_A:
            begin
                cur_next    = clamped;
                dist_next   = '0;
                err_next    = 1'b0;
                before_next = 1'b0;
                equal_next  = 1'b0;
            end
            ST_CLAMP_B:
            begin
                // Walk forward from the earlier date towards the later one.
                before_next = (cur_reg < clamped);
                equal_next  = (cur_reg == clamped);
                if (cur_reg < clamped)
                begin
                    tgt_next = clamped;
                end
                else
                begin
                    cur_next = clamped;
                    tgt_next = cur_reg;
                end
            end
            ST_RUN:
            begin
                if (run_done)
                begin
                    err_next = run_err;
                end
                else
                begin
                    cur_next  = unit_out;
                    cnt_next  = cnt_reg - 1'b1;
                    dist_next = dist_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_date_next   = '0;
                    out_dist_next   = '0;
                    out_before_next = 1'b0;
                    out_equal_next  = 1'b0;
                    out_err_next    = 1'b0;
                    case (kind_reg) inside
                        KIND_ADD, KIND_SUB:
                        begin
                            out_date_next = cur_reg;
                            out_err_next  = err_reg;
                        end
                        KIND_CMP:
                        begin
                            out_dist_next   = dist_reg;
                            out_before_next = before_reg;
                            out_equal_next  = equal_reg;
                        end
                        default:
                        begin
                            out_err_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        raw_a_reg      <= raw_a_next;
        raw_b_reg      <= raw_b_next;
        cur_reg        <= cur_next;
        tgt_reg        <= tgt_next;
        cnt_reg        <= cnt_next;
        dist_reg       <= dist_next;
        err_reg        <= err_next;
        before_reg     <= before_next;
        equal_reg      <= equal_next;
        out_date_reg   <= out_date_next;
        out_dist_reg   <= out_dist_next;
        out_before_reg <= out_before_next;
        out_equal_reg  <= out_equal_next;
        out_err_reg    <= out_err_next;
    end

    assign out_valid     = out_valid_reg;
    assign day_out       = out_date_reg.day;
    assign month_out     = out_date_reg.month;
    assign year_out      = out_date_reg.year;
    assign distance_days = out_dist_reg;
    assign a_before_b    = out_before_reg;
    assign a_equals_b    = out_equal_reg;
    assign range_error   = out_err_reg;

endmodule

`default_nettype wire
